/* hw/rtl/ncl_pkg.sv */
// Shared constants, types and saturating arithmetic for nearest cluster assignment.
`default_nettype none
package ncl_pkg;
  localparam int MAX_CLUSTERS = 64;
  localparam int CLUSTER_BITS = 6;
  localparam int DIM_BITS     = 12;
  localparam int CNT_BITS     = 24;
  localparam int NCL_BITS     = 7;
  localparam int CENT_ABITS   = CLUSTER_BITS + DIM_BITS;

  localparam logic [1:0] ACT_LOAD_CENT   = 2'd0;
  localparam logic [1:0] ACT_LOAD_SCALAR = 2'd1;
  localparam logic [1:0] ACT_QUERY       = 2'd2;

  typedef struct packed {
    logic               done;
    logic signed [63:0] quotient;
  } ncl_div_res_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else sat_add = s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) sat_sub = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else sat_sub = s[63:0];
  endfunction
endpackage
`default_nettype wire

/* hw/rtl/nearest_cluster_assign_top.sv */
// Nearest cluster assignment: centroid store, per-cluster accumulators, scoring sequencer.
// Centroid element load writes the element, then updates its norm; scalar load writes
// mean square and member count. Each query entry updates every cluster's dot product in a
// pipelined sweep of the centroid memory, one cluster per cycle.
// On the last entry, each active cluster is scored in turn via the 64-step divider.
// Synchronous reset clears per-cluster valid bits at once: norms and dot sums read zero.
`default_nettype none
module nearest_cluster_assign_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [6:0]   cfg_wdata,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // cluster[5:0], dim[17:6], value[49:18], mean_square[113:50], member_count[137:114]
  input  wire logic [143:0] s_tdata,
  // action[1:0]
  input  wire logic [1:0]   s_tuser,
  input  wire logic         s_tlast,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // best_cluster[6:0], best_score[70:7]
  output logic [71:0]       m_tdata
);
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LDRD  = 4'd1;
  localparam logic [3:0] ST_LDWR  = 4'd2;
  localparam logic [3:0] ST_MSWR  = 4'd3;
  localparam logic [3:0] ST_QSQ   = 4'd4;
  localparam logic [3:0] ST_QNORM = 4'd5;
  localparam logic [3:0] ST_QRUN  = 4'd6;
  localparam logic [3:0] ST_SRD   = 4'd7;
  localparam logic [3:0] ST_SUM1  = 4'd8;
  localparam logic [3:0] ST_SUM2  = 4'd9;
  localparam logic [3:0] ST_SUM3  = 4'd10;
  localparam logic [3:0] ST_DIV   = 4'd11;
  localparam logic [3:0] ST_CMP   = 4'd12;
  localparam logic [3:0] ST_DONE  = 4'd13;

  logic [3:0] state;
  logic [6:0] num_clusters;
  logic [5:0] cl;
  logic [11:0] dim;
  logic signed [31:0] val;
  logic signed [63:0] ms_in;
  logic [23:0] cnt_in;
  logic last;

  logic signed [63:0] sq, qn, acc, best_score;
  logic [6:0] k, ri, n, best;
  logic [63:0] nvalid, dvalid;
  logic v1, v2;
  logic [5:0] k1, k2;
  logic signed [63:0] prod, dold;

  logic [31:0] cent_rd;
  logic [63:0] norm_rd, dot_rd, ms_rd;
  logic [23:0] cnt_rd;
  logic [5:0] norm_raddr, dot_raddr;
  logic norm_we, dot_we, div_start;
  logic signed [63:0] norm_cur, dot_cur, norm_new, dot_new, score, acc_norm;
  ncl_pkg::ncl_div_res_t div_res;

  assign s_tready = (state == ST_IDLE);
  assign n = (num_clusters == 7'd0) ? 7'd1 :
             (num_clusters > 7'(ncl_pkg::MAX_CLUSTERS)) ? 7'(ncl_pkg::MAX_CLUSTERS)
                                                        : num_clusters;

  assign norm_raddr = (state == ST_LDRD) ? cl : k[5:0];
  assign dot_raddr  = (state == ST_QRUN) ? ri[5:0] : k[5:0];
  assign norm_we    = (state == ST_LDWR);
  assign dot_we     = (state == ST_QRUN) && v2;
  assign norm_cur   = nvalid[cl] ? norm_rd : 64'sd0;
  assign norm_new   = ncl_pkg::sat_add(norm_cur, sq);
  assign dot_new    = ncl_pkg::sat_add(dold, prod);
  assign dot_cur    = dvalid[k[5:0]] ? dot_rd : 64'sd0;
  assign acc_norm   = ncl_pkg::sat_add(acc, nvalid[k[5:0]] ? norm_rd : 64'sd0);
  assign div_start  = (state == ST_SUM3);
  assign score      = ncl_pkg::sat_sub(ms_rd, div_res.quotient);

  ncl_ram #(.WIDTH(32), .ABITS(ncl_pkg::CENT_ABITS)) u_cent (
    .clk, .we(state == ST_LDRD), .waddr({cl, dim}), .wdata(val),
    .raddr({ri[5:0], dim}), .rdata(cent_rd));
  ncl_ram #(.WIDTH(64), .ABITS(ncl_pkg::CLUSTER_BITS)) u_norm (
    .clk, .we(norm_we), .waddr(cl), .wdata(norm_new),
    .raddr(norm_raddr), .rdata(norm_rd));
  ncl_ram #(.WIDTH(64), .ABITS(ncl_pkg::CLUSTER_BITS)) u_dot (
    .clk, .we(dot_we), .waddr(k2), .wdata(dot_new),
    .raddr(dot_raddr), .rdata(dot_rd));
  ncl_ram #(.WIDTH(64), .ABITS(ncl_pkg::CLUSTER_BITS)) u_ms (
    .clk, .we(state == ST_MSWR), .waddr(cl), .wdata(ms_in),
    .raddr(k[5:0]), .rdata(ms_rd));
  ncl_ram #(.WIDTH(24), .ABITS(ncl_pkg::CLUSTER_BITS)) u_cnt (
    .clk, .we(state == ST_MSWR), .waddr(cl), .wdata(cnt_in),
    .raddr(k[5:0]), .rdata(cnt_rd));

  ncl_div u_div (
    .clk, .rst, .start(div_start), .dividend(acc_norm), .count(cnt_rd), .res(div_res));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      num_clusters <= 7'd1;
      nvalid       <= '0;
      dvalid       <= '0;
      qn           <= '0;
      m_tvalid     <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
    end else begin
      if (cfg_we) num_clusters <= cfg_wdata;
      if (m_tvalid && m_tready && state != ST_DONE) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cl     <= s_tdata[5:0];
            dim    <= s_tdata[17:6];
            val    <= s_tdata[49:18];
            ms_in  <= s_tdata[113:50];
            cnt_in <= s_tdata[137:114];
            last   <= s_tlast;
            unique case (s_tuser)
              ncl_pkg::ACT_LOAD_CENT:   state <= ST_LDRD;
              ncl_pkg::ACT_LOAD_SCALAR: state <= ST_MSWR;
              ncl_pkg::ACT_QUERY:       state <= ST_QSQ;
              default:                  state <= ST_IDLE;
            endcase
          end
        end
        ST_LDRD: begin
          sq    <= 64'(val * val);
          state <= ST_LDWR;
        end
        ST_LDWR: begin
          nvalid[cl] <= 1'b1;
          state      <= ST_IDLE;
        end
        ST_MSWR: state <= ST_IDLE;
        ST_QSQ: begin
          sq    <= 64'(val * val);
          state <= ST_QNORM;
        end
        ST_QNORM: begin
          qn    <= ncl_pkg::sat_add(qn, sq);
          ri    <= 7'd0;
          v1    <= 1'b0;
          v2    <= 1'b0;
          state <= ST_QRUN;
        end
        ST_QRUN: begin
          // issue one cluster read per cycle, multiply, then accumulate and write back
          v1 <= (ri != 7'(ncl_pkg::MAX_CLUSTERS));
          k1 <= ri[5:0];
          if (ri != 7'(ncl_pkg::MAX_CLUSTERS)) ri <= ri + 7'd1;
          v2   <= v1;
          k2   <= k1;
          prod <= 64'(val * $signed(cent_rd));
          dold <= dvalid[k1] ? dot_rd : 64'sd0;
          if (v2) dvalid[k2] <= 1'b1;
          if (ri == 7'(ncl_pkg::MAX_CLUSTERS) && !v1 && !v2) begin
            k     <= 7'd0;
            state <= last ? ST_SRD : ST_IDLE;
          end
        end
        ST_SRD: state <= ST_SUM1;
        ST_SUM1: begin
          acc   <= ncl_pkg::sat_add(dot_cur, dot_cur);
          state <= ST_SUM2;
        end
        ST_SUM2: begin
          acc   <= ncl_pkg::sat_add(qn, acc);
          state <= ST_SUM3;
        end
        // the divider takes the sum with the centroid norm added
        ST_SUM3: state <= ST_DIV;
        ST_DIV: if (div_res.done) state <= ST_CMP;
        ST_CMP: begin
          // lower index wins ties
          if (k == 7'd0 || score < best_score) begin
            best       <= k;
            best_score <= score;
          end
          k     <= k + 7'd1;
          state <= (k + 7'd1 == n) ? ST_DONE : ST_SRD;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, best_score, best + 7'd1};
            dvalid   <= '0;
            qn       <= '0;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/ncl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ncl_ram #(
  parameter int WIDTH = 32,
  parameter int ABITS = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [ABITS-1:0] waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [ABITS-1:0] raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [2**ABITS];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* hw/rtl/ncl_div.sv */
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module ncl_div (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic signed [63:0]     dividend,
  input  wire logic [ncl_pkg::CNT_BITS-1:0] count,
  output ncl_pkg::ncl_div_res_t       res
);
  logic [63:0] q;
  logic [ncl_pkg::CNT_BITS:0] d;
  logic [ncl_pkg::CNT_BITS:0] rem;
  logic [ncl_pkg::CNT_BITS+1:0] trial;
  logic [6:0] cnt;
  logic busy, neg, done;

  assign trial = {rem, q[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
    if (start) begin
      neg <= dividend[63];
      q   <= dividend[63] ? 64'(-dividend) : dividend;
      d   <= {1'b0, count} + 25'd1;
      rem <= '0;
    end else if (busy) begin
      // shift in the next dividend bit and subtract where it fits
      if (trial >= {1'b0, d}) begin
        rem <= (ncl_pkg::CNT_BITS+1)'(trial - {1'b0, d});
        q   <= {q[62:0], 1'b1};
      end else begin
        rem <= trial[ncl_pkg::CNT_BITS:0];
        q   <= {q[62:0], 1'b0};
      end
    end
  end

  assign res.done     = done;
  assign res.quotient = neg ? -q : q;
endmodule
`default_nettype wire

/* tb/nearest_cluster_assign_checker.sv */
// Checker for nearest cluster assignment: tracks centroid state and compares every result.
module nearest_cluster_assign_checker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [6:0]   cfg_wdata,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [143:0] s_tdata,
  input  wire logic [1:0]   s_tuser,
  input  wire logic         s_tlast,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [71:0]  m_tdata,
  output int                mismatches,
  output int                outstanding
);
  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, 63'd0};

  typedef struct {
    logic [6:0]         cluster;
    logic signed [63:0] score;
  } assignment_t;

  logic signed [31:0] cent_mem [0:ncl_pkg::MAX_CLUSTERS*4096-1];
  logic signed [63:0] cent_norm [0:ncl_pkg::MAX_CLUSTERS-1];
  logic signed [63:0] ms_mem [0:ncl_pkg::MAX_CLUSTERS-1];
  logic [23:0]        cnt_mem [0:ncl_pkg::MAX_CLUSTERS-1];
  logic signed [63:0] dot_sum [0:ncl_pkg::MAX_CLUSTERS-1];
  logic signed [63:0] query_norm;
  logic [6:0]         active_clusters;
  assignment_t        expected_assign [$];

  function automatic logic signed [63:0] add_clamped(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
    logic signed [64:0] wide;
    wide = 65'(a) + 65'(b);
    if (wide > 65'(S64_MAX)) return S64_MAX;
    if (wide < 65'(S64_MIN)) return S64_MIN;
    return wide[63:0];
  endfunction

  // Score all active clusters and pick the lowest; lower index wins ties.
  function automatic assignment_t pick_nearest();
    assignment_t        best;
    int                 n;
    logic signed [63:0] spread, score;
    n = active_clusters;
    if (n < 1) n = 1;
    if (n > ncl_pkg::MAX_CLUSTERS) n = ncl_pkg::MAX_CLUSTERS;
    best.cluster = 7'd1;
    best.score   = '0;
    for (int k = 0; k < n; k++) begin
      spread = add_clamped(query_norm, add_clamped(dot_sum[k], dot_sum[k]));
      spread = add_clamped(spread, cent_norm[k]);
      spread = spread / $signed({40'd0, cnt_mem[k]} + 64'sd1);
      if (spread == S64_MIN) score = add_clamped(add_clamped(ms_mem[k], S64_MAX), 64'sd1);
      else score = add_clamped(ms_mem[k], -spread);
      if (k == 0 || score < best.score) begin
        best.cluster = 7'(k + 1);
        best.score   = score;
      end
    end
    return best;
  endfunction

  always @(posedge clk) begin
    logic [5:0]         cl;
    logic [11:0]        dm;
    logic signed [63:0] val;
    assignment_t        got, want;
    if (rst) begin
      for (int k = 0; k < ncl_pkg::MAX_CLUSTERS; k++) begin
        cent_norm[k] = '0;
        dot_sum[k]   = '0;
        ms_mem[k]    = '0;
        cnt_mem[k]   = '0;
      end
      query_norm      = '0;
      active_clusters = 7'd1;
      expected_assign.delete();
      mismatches      = 0;
    end else begin
      if (cfg_we) active_clusters = cfg_wdata;
      if (s_tvalid && s_tready) begin
        cl  = s_tdata[5:0];
        dm  = s_tdata[17:6];
        val = 64'($signed(s_tdata[49:18]));
        case (s_tuser)
          ncl_pkg::ACT_LOAD_CENT: begin
            cent_mem[{cl, dm}] = val[31:0];
            cent_norm[cl] = add_clamped(cent_norm[cl], val * val);
          end
          ncl_pkg::ACT_LOAD_SCALAR: begin
            ms_mem[cl]  = $signed(s_tdata[113:50]);
            cnt_mem[cl] = s_tdata[137:114];
          end
          ncl_pkg::ACT_QUERY: begin
            query_norm = add_clamped(query_norm, val * val);
            for (int k = 0; k < ncl_pkg::MAX_CLUSTERS; k++)
              dot_sum[k] = add_clamped(dot_sum[k], val * 64'(cent_mem[{6'(k), dm}]));
            if (s_tlast) begin
              expected_assign.push_back(pick_nearest());
              for (int k = 0; k < ncl_pkg::MAX_CLUSTERS; k++) dot_sum[k] = '0;
              query_norm = '0;
            end
          end
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.cluster = m_tdata[6:0];
        got.score   = $signed(m_tdata[70:7]);
        if (expected_assign.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: cluster %0d score %0d", got.cluster, got.score);
          mismatches++;
        end else begin
          want = expected_assign.pop_front();
          if (got.cluster !== want.cluster || got.score !== want.score) begin
            if (mismatches < 10)
              $display("mismatch: cluster exp %0d got %0d, score exp %0d got %0d",
                       want.cluster, got.cluster, want.score, got.score);
            mismatches++;
          end
        end
      end
    end
    outstanding = expected_assign.size();
  end
endmodule

/* tb/nearest_cluster_assign_top_tb.sv */
// Testbench top for nearest cluster assignment: clock, reset, stimulus and verdict.
module nearest_cluster_assign_top_tb;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 10_000_000;
  localparam int         SETTLE = 300;

  logic         clk, rst, cfg_we;
  logic [6:0]   cfg_wdata;
  logic         s_tvalid, s_tready, s_tlast, m_tvalid, m_tready;
  logic [143:0] s_tdata;
  logic [1:0]   s_tuser;
  logic [71:0]  m_tdata;
  int           mismatches, outstanding;
  int           cycles;
  bit           src_bursty, sink_bursty;
  logic [11:0]  loaded_dims [8];
  logic [6:0]   cluster_settings [6] = '{7'd64, 7'd0, 7'd127, 7'd33, 7'd5, 7'd1};

  nearest_cluster_assign_top u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .s_tlast(s_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  nearest_cluster_assign_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .s_tlast(s_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
    endcase
  endfunction

  function automatic logic [63:0] pick_wide();
    case ($urandom_range(0, 4))
      0: return {1'b0, {63{1'b1}}};
      1: return {1'b1, 63'd0};
      2: return {$urandom, $urandom};
      default: return 64'($signed({$urandom, $urandom}) >>> 24);
    endcase
  endfunction

  task automatic send_item(input logic [1:0] action, input logic [5:0] cl,
                           input logic [11:0] dm, input logic [31:0] val,
                           input logic [63:0] ms, input logic [23:0] cnt, input logic lst);
    int gap;
    gap = src_bursty ? 0 : $urandom_range(0, 12);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tdata  <= {6'd0, cnt, ms, val, dm, cl};
    s_tuser  <= action;
    s_tlast  <= lst;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_query(input int entries);
    for (int e = 0; e < entries; e++)
      send_item(ncl_pkg::ACT_QUERY, 6'($urandom), loaded_dims[$urandom_range(0, 7)],
                pick_value(), 64'({$urandom, $urandom}), 24'($urandom), e == entries - 1);
  endtask

  // Hold until every result is out and the block has gone quiet.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_clusters(input logic [6:0] n);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    forever begin
      int stall;
      if ($urandom_range(0, 60) == 0) sink_bursty = ~sink_bursty;
      stall = sink_bursty ? 0 : $urandom_range(0, 12);
      repeat (stall) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin
    bit dup;
    cycles = 0;
    rst = 1'b1;
    cfg_we = 1'b0; cfg_wdata = 7'd1;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = ncl_pkg::ACT_LOAD_CENT; s_tlast = 1'b0;
    m_tready = 1'b0;
    src_bursty = 1'b0; sink_bursty = 1'b0;
    loaded_dims[0] = 12'd0;
    loaded_dims[1] = 12'hFFF;
    loaded_dims[2] = 12'hAAA;
    loaded_dims[3] = 12'h555;
    for (int i = 4; i < 8; i++) begin
      do begin
        loaded_dims[i] = 12'($urandom);
        dup = 1'b0;
        for (int j = 0; j < i; j++) if (loaded_dims[j] == loaded_dims[i]) dup = 1'b1;
      end while (dup);
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_clusters(7'd1);

    // Every query dim must be present for all clusters, so load whole columns.
    for (int d = 0; d < 8; d++)
      for (int c = 0; c < ncl_pkg::MAX_CLUSTERS; c++) begin
        if (($urandom_range(0, 40)) == 0) src_bursty = ~src_bursty;
        send_item(ncl_pkg::ACT_LOAD_CENT, 6'(c), loaded_dims[d], pick_value(),
                  64'($urandom), 24'($urandom), 1'($urandom));
      end
    send_item(ncl_pkg::ACT_LOAD_SCALAR, 6'd0, 12'($urandom), 32'($urandom),
              {1'b0, {63{1'b1}}}, 24'd0, 1'b1);
    send_item(ncl_pkg::ACT_LOAD_SCALAR, 6'd1, 12'($urandom), 32'($urandom),
              {1'b1, 63'd0}, 24'hFF_FFFF, 1'b0);
    for (int c = 2; c < ncl_pkg::MAX_CLUSTERS; c++)
      send_item(ncl_pkg::ACT_LOAD_SCALAR, 6'(c), 12'($urandom), 32'($urandom), pick_wide(),
                ($urandom_range(0, 3) == 0) ? 24'hFF_FFFF : 24'($urandom_range(0, 200)),
                1'($urandom));

    // Extremes, repeated dim, single-entry query, and ignored action with last set.
    send_item(ncl_pkg::ACT_QUERY, 6'd0, 12'd0, 32'h7FFF_FFFF, '0, '0, 1'b0);
    send_item(ncl_pkg::ACT_QUERY, 6'd0, 12'hFFF, 32'h8000_0000, '0, '0, 1'b0);
    send_item(ncl_pkg::ACT_QUERY, 6'd0, 12'hFFF, 32'h8000_0000, '0, '0, 1'b1);
    send_item(ncl_pkg::ACT_QUERY, 6'd0, 12'hAAA, 32'h0001_0000, '0, '0, 1'b1);
    send_item(ACT_UNUSED, 6'h3F, 12'hFFF, 32'hFFFF_FFFF, '1, '1, 1'b1);
    send_item(ncl_pkg::ACT_QUERY, 6'h3F, 12'h555, 32'h0000_0000, '1, '1, 1'b1);
    drain();

    foreach (cluster_settings[p]) begin
      write_clusters(cluster_settings[p]);
      for (int q = 0; q < 8; q++) begin
        if ($urandom_range(0, 4) == 0) src_bursty = ~src_bursty;
        if ($urandom_range(0, 3) == 0)
          send_item(ncl_pkg::ACT_LOAD_SCALAR, 6'($urandom), 12'($urandom), 32'($urandom),
                    pick_wide(), 24'($urandom_range(0, 1000)), 1'($urandom));
        if ($urandom_range(0, 5) == 0)
          send_item(ACT_UNUSED, 6'($urandom), 12'($urandom), 32'($urandom),
                    64'({$urandom, $urandom}), 24'($urandom), 1'($urandom));
        send_query($urandom_range(1, 6));
      end
      drain();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

/* nearest_cluster_assign_top.f */
hw/rtl/ncl_pkg.sv
hw/rtl/ncl_ram.sv
hw/rtl/ncl_div.sv
hw/rtl/nearest_cluster_assign_top.sv
tb/nearest_cluster_assign_checker.sv
tb/nearest_cluster_assign_top_tb.sv
